@@ rtl/core/cm3_pkg.sv @@
// Shared types and constants for the three-dimensional chaotic map byte generator.
package cm3_pkg;

    // Field and arithmetic widths
    localparam int COORD_W   = 32;                    // UQ0.32 coordinates
    localparam int GAIN_FRAC = 27;                    // UQ5.27 gains
    localparam int SCALE_W   = 32;
    localparam int DISC_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int MUL_W     = COORD_W + 1;           // operand width of the serial multiplier
    localparam int PROD_W    = 2 * MUL_W;
    localparam int CNT_W     = $clog2(MUL_W + 1);
    localparam int SCALED_W  = 2 * COORD_W - GAIN_FRAC; // gain * coordinate, realigned
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int S_DATA_W  = 3 * COORD_W;
    localparam int S_USER_W  = 1;
    localparam int M_DATA_W  = ((COORD_W + BYTE_W + 7) / 8) * 8;

    // Operation codes carried on s_tuser
    localparam logic OP_SEED = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PSI      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LAMBDA   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_SCALE    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DISCARD_STEPS = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [COORD_W-1:0] GAIN_PSI_RST    = 32'h4000_0000;
    localparam logic [COORD_W-1:0] GAIN_LAMBDA_RST = 32'h4000_0000;
    localparam logic [SCALE_W-1:0] BYTE_SCALE_RST  = 32'd1000000;
    localparam logic [DISC_W-1:0]  DISCARD_RST     = 16'd1000;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GX,
        ST_MUL_YZ,
        ST_MUL_B,
        ST_MUL_BYTE,
        ST_EMIT
    } cm3_state_t;

    // Request to the serial multiplier and its status
    typedef struct packed {
        logic             go;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } cm3_mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cm3_mul_stat_t;

endpackage

@@ rtl/core/cm3_serial_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module cm3_serial_mul (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cm3_pkg::cm3_mul_req_t        req,
    output cm3_pkg::cm3_mul_stat_t       stat,
    output logic [cm3_pkg::PROD_W-1:0]   product
);
    import cm3_pkg::*;

    logic [MUL_W-1:0]  mcand_reg;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [MUL_W:0]    sum;

    // Add the multiplicand into the upper half when the current multiplier bit is set
    always_comb begin
        sum = {1'b0, acc_reg[PROD_W-1:MUL_W]} + (acc_reg[0] ? {1'b0, mcand_reg} : '0);
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.go) begin
            acc_next = {{MUL_W{1'b0}}, req.b};
            cnt_next = CNT_W'(MUL_W);
        end else if (cnt_reg != '0) begin
            acc_next  = {sum, acc_reg[MUL_W-1:1]};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // Hold the operand and accumulator; count iterations
    always_ff @(posedge aclk) begin
        if (req.go) begin
            mcand_reg <= req.a;
        end
        acc_reg <= acc_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule

@@ rtl/core/chaotic_map3d_byte_generator.sv @@
// Top level of the three-dimensional chaotic map byte generator.
//
// A seed request (op 0 on s_tuser) loads p, q and r and restarts the warm-up
// count. A step request (op 1) advances the map; every product is formed by
// one shared bit-serial multiplier, and a step needs nine of them (three per
// coordinate), and the block takes no new request until the step ends. A step
// that yields a result adds the point * byte_scale product and then loads the
// output register once it is free. The output register holds a result while
// the next request is taken.
module chaotic_map3d_byte_generator (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cm3_pkg::S_DATA_W-1:0]      s_tdata,   // seed_p, seed_q, seed_r
    input  logic [cm3_pkg::S_USER_W-1:0]      s_tuser,   // op
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cm3_pkg::M_DATA_W-1:0]      m_tdata,   // point, out_byte
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cm3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cm3_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import cm3_pkg::*;

    localparam logic [MUL_W-1:0] ONE_Q = MUL_W'(1) << COORD_W;

    // Configuration registers
    logic [COORD_W-1:0] gain_psi_reg, gain_lambda_reg;
    logic [SCALE_W-1:0] byte_scale_reg;
    logic [DISC_W-1:0]  discard_steps_reg;

    // Map state
    cm3_state_t         state_reg, state_next;
    logic [1:0]         k_reg, k_next;
    logic               go_reg, go_next;
    logic [COORD_W-1:0] coord_p_reg, coord_p_next;
    logic [COORD_W-1:0] coord_q_reg, coord_q_next;
    logic [COORD_W-1:0] coord_r_reg, coord_r_next;
    logic [DISC_W-1:0]  warmup_reg, warmup_next;
    logic [COORD_W-1:0] new_p_reg, new_p_next;
    logic [COORD_W-1:0] new_q_reg, new_q_next;
    logic [COORD_W-1:0] abs_reg, abs_next;
    logic [COORD_W-1:0] t_reg, t_next;

    // Output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [COORD_W-1:0] m_point_reg, m_point_next;
    logic [BYTE_W-1:0]  m_byte_reg, m_byte_next;

    // Datapath
    logic [COORD_W-1:0]  x, y, z;
    logic [MUL_W-1:0]    one_minus_z;
    logic [SCALED_W-1:0] gx;
    logic [COORD_W-1:0]  abs_val, sum_val;
    logic                s_fire;

    cm3_mul_req_t        mul_req;
    cm3_mul_stat_t       mul_stat;
    logic [PROD_W-1:0]   mul_prod;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = M_DATA_W'({m_byte_reg, m_point_reg});

    // Take configuration writes; ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_psi_reg      <= GAIN_PSI_RST;
            gain_lambda_reg   <= GAIN_LAMBDA_RST;
            byte_scale_reg    <= BYTE_SCALE_RST;
            discard_steps_reg <= DISCARD_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_GAIN_PSI:      gain_psi_reg      <= cfg_data[COORD_W-1:0];
                REG_GAIN_LAMBDA:   gain_lambda_reg   <= cfg_data[COORD_W-1:0];
                REG_BYTE_SCALE:    byte_scale_reg    <= cfg_data[SCALE_W-1:0];
                REG_DISCARD_STEPS: discard_steps_reg <= cfg_data[DISC_W-1:0];
                default: ;
            endcase
        end
    end

    // Rotate the coordinates for the one being updated
    always_comb begin
        unique case (k_reg)
            2'd0: begin
                x = coord_p_reg; y = coord_q_reg; z = coord_r_reg;
            end
            2'd1: begin
                x = coord_q_reg; y = coord_r_reg; z = coord_p_reg;
            end
            default: begin
                x = coord_r_reg; y = coord_p_reg; z = coord_q_reg;
            end
        endcase
        one_minus_z = ONE_Q - {1'b0, z};
    end

    // Select multiplier operands for the product in flight
    always_comb begin
        mul_req.go = go_reg;
        unique case (state_reg)
            ST_MUL_GX: begin
                mul_req.a = {1'b0, gain_psi_reg};
                mul_req.b = {1'b0, x};
            end
            ST_MUL_YZ: begin
                mul_req.a = {1'b0, y};
                mul_req.b = one_minus_z;
            end
            ST_MUL_B: begin
                mul_req.a = {1'b0, gain_lambda_reg};
                mul_req.b = {1'b0, t_reg};
            end
            default: begin
                mul_req.a = {1'b0, coord_p_reg};
                mul_req.b = {1'b0, byte_scale_reg};
            end
        endcase
    end

    cm3_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .stat    (mul_stat),
        .product (mul_prod)
    );

    // |1 - g*x| modulo one, and the sum with the second term modulo one
    always_comb begin
        gx      = mul_prod[GAIN_FRAC +: SCALED_W];
        abs_val = (gx[SCALED_W-1:COORD_W] != '0) ? gx[COORD_W-1:0]
                                                  : (~gx[COORD_W-1:0] + COORD_W'(1));
        sum_val = abs_reg + mul_prod[GAIN_FRAC +: COORD_W];
    end

    // Sequence the products of one step
    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        go_next       = 1'b0;
        coord_p_next  = coord_p_reg;
        coord_q_next  = coord_q_reg;
        coord_r_next  = coord_r_reg;
        warmup_next   = warmup_reg;
        new_p_next    = new_p_reg;
        new_q_next    = new_q_reg;
        abs_next      = abs_reg;
        t_next        = t_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_point_next  = m_point_reg;
        m_byte_next   = m_byte_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser[0] == OP_SEED) begin
                        coord_p_next = s_tdata[0*COORD_W +: COORD_W];
                        coord_q_next = s_tdata[1*COORD_W +: COORD_W];
                        coord_r_next = s_tdata[2*COORD_W +: COORD_W];
                        warmup_next  = discard_steps_reg;
                    end else begin
                        k_next     = 2'd0;
                        state_next = ST_MUL_GX;
                        go_next    = 1'b1;
                    end
                end
            end
            ST_MUL_GX: begin
                if (mul_stat.done) begin
                    abs_next   = abs_val;
                    state_next = ST_MUL_YZ;
                    go_next    = 1'b1;
                end
            end
            ST_MUL_YZ: begin
                if (mul_stat.done) begin
                    t_next     = mul_prod[COORD_W +: COORD_W];
                    state_next = ST_MUL_B;
                    go_next    = 1'b1;
                end
            end
            ST_MUL_B: begin
                if (mul_stat.done) begin
                    if (k_reg == 2'd0) begin
                        new_p_next = sum_val;
                        k_next     = 2'd1;
                        state_next = ST_MUL_GX;
                        go_next    = 1'b1;
                    end else if (k_reg == 2'd1) begin
                        new_q_next = sum_val;
                        k_next     = 2'd2;
                        state_next = ST_MUL_GX;
                        go_next    = 1'b1;
                    end else begin
                        // commit all three coordinates together
                        coord_p_next = new_p_reg;
                        coord_q_next = new_q_reg;
                        coord_r_next = sum_val;
                        if (warmup_reg != '0) begin
                            warmup_next = warmup_reg - DISC_W'(1);
                            state_next  = ST_IDLE;
                        end else begin
                            state_next = ST_MUL_BYTE;
                            go_next    = 1'b1;
                        end
                    end
                end
            end
            ST_MUL_BYTE: begin
                if (mul_stat.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_point_next  = coord_p_reg;
                    m_byte_next   = mul_prod[COORD_W +: BYTE_W];
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance the sequencer, map state and output register
    always_ff @(posedge aclk) begin
        new_p_reg   <= new_p_next;
        new_q_reg   <= new_q_next;
        abs_reg     <= abs_next;
        t_reg       <= t_next;
        m_point_reg <= m_point_next;
        m_byte_reg  <= m_byte_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_reg        <= 2'd0;
            go_reg       <= 1'b0;
            coord_p_reg  <= '0;
            coord_q_reg  <= '0;
            coord_r_reg  <= '0;
            warmup_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            go_reg       <= go_next;
            coord_p_reg  <= coord_p_next;
            coord_q_reg  <= coord_q_next;
            coord_r_reg  <= coord_r_next;
            warmup_reg   <= warmup_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // A new product is never started while the multiplier is still iterating
    a_mul_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        go_reg |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    // A seed request restarts the warm-up count from the configured value
    a_seed_warmup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == OP_SEED))
        |=> (warmup_reg == $past(discard_steps_reg)))
        else $error("warm-up count not restarted by seed");

    // Results are only produced once warm-up has run out
    a_emit_after_warmup: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (warmup_reg == '0))
        else $error("result produced during warm-up");

endmodule
